[rtl/epv_pkg.sv]
// package for the eye position solver: widths and shared constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package epv_pkg;
  localparam int unsigned InW       = 24;
  localparam int unsigned OutW      = 32;
  localparam int unsigned FracBitsD = 16;
  localparam int unsigned CofW      = 2 * InW + 1;     // cross product term
  localparam int unsigned DetW      = CofW + InW + 2;  // determinant
  localparam int unsigned TopW      = CofW + InW + 2;  // weighted cofactor sum
endpackage
`default_nettype wire

[rtl/eye_position_from_view_matrix.sv]
// eye position solver top: cofactors, determinant, weighted sums, divide
// depends on epv_pkg and epv_div
// pipeline: 5 front stages, 34 divider stages and the output register
// throughput: one matrix word per cycle; the whole pipe advances when the
// output register is empty or being taken
// rst_n synchronous active low clears every valid bit; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none
module eye_position_from_view_matrix #(
  parameter int unsigned FRAC_BITS = epv_pkg::FracBitsD
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row0_col0,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row0_col1,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row0_col2,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row0_offset,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row1_col0,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row1_col1,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row1_col2,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row1_offset,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row2_col0,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row2_col1,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row2_col2,
  input  wire logic signed [epv_pkg::InW-1:0]     in_row2_offset,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [epv_pkg::OutW-1:0]         out_pos_x,
  output logic signed [epv_pkg::OutW-1:0]         out_pos_y,
  output logic signed [epv_pkg::OutW-1:0]         out_pos_z,
  output logic                                    out_singular
);
  localparam int unsigned IW = epv_pkg::InW;
  localparam int unsigned PW = 2 * IW;
  localparam int unsigned CW = epv_pkg::CofW;
  localparam int unsigned MW = CW + IW;
  localparam int unsigned TW = epv_pkg::TopW;

  // global enable: stall everything while the output word waits
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: input register
  logic              v1_r;
  logic signed [IW-1:0] n_r [3][3];
  logic signed [IW-1:0] t1_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
    if (en) begin
      n_r[0][0] <= in_row0_col0; n_r[0][1] <= in_row0_col1; n_r[0][2] <= in_row0_col2;
      n_r[1][0] <= in_row1_col0; n_r[1][1] <= in_row1_col1; n_r[1][2] <= in_row1_col2;
      n_r[2][0] <= in_row2_col0; n_r[2][1] <= in_row2_col1; n_r[2][2] <= in_row2_col2;
      t1_r[0] <= in_row0_offset; t1_r[1] <= in_row1_offset; t1_r[2] <= in_row2_offset;
    end
  end

  // stage 2: 18 products of the three cross products, registered
  logic v2_r;
  logic signed [PW-1:0] pa_r [3][3];
  logic signed [PW-1:0] pb_r [3][3];
  logic signed [IW-1:0] t2_r [3];
  logic signed [IW-1:0] n2_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // cofactor k = n[k+1] x n[k+2]
        for (int j = 0; j < 3; j++) begin
          pa_r[k][j] <= PW'(n_r[(k+1)%3][(j+1)%3] * n_r[(k+2)%3][(j+2)%3]);
          pb_r[k][j] <= PW'(n_r[(k+1)%3][(j+2)%3] * n_r[(k+2)%3][(j+1)%3]);
        end
        t2_r[k] <= t1_r[k];
        n2_r[k] <= n_r[0][k];
      end
    end
  end

  // stage 3: cofactor terms
  logic v3_r;
  logic signed [CW-1:0] c_r [3][3];
  logic signed [IW-1:0] t3_r [3];
  logic signed [IW-1:0] n3_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++)
          c_r[k][j] <= CW'(pa_r[k][j]) - CW'(pb_r[k][j]);
        t3_r[k] <= t2_r[k];
        n3_r[k] <= n2_r[k];
      end
    end
  end

  // stage 4: products of cofactors with translation and first row
  logic v4_r;
  logic signed [MW-1:0] m_r [3][3];
  logic signed [MW-1:0] d_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++)
          m_r[k][j] <= MW'(c_r[k][j] * t3_r[k]);
        d_r[k] <= MW'(c_r[0][k] * n3_r[k]);
      end
    end
  end

  // stage 5: sums; denominator is the negated determinant
  logic v5_r;
  logic signed [TW-1:0] top_r [3];
  logic signed [TW-1:0] den_r;
  logic                 zero_r;
  logic signed [TW-1:0] det;
  assign det = TW'(d_r[0]) + TW'(d_r[1]) + TW'(d_r[2]);
  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
    if (en) begin
      for (int j = 0; j < 3; j++)
        top_r[j] <= TW'(m_r[0][j]) + TW'(m_r[1][j]) + TW'(m_r[2][j]);
      den_r  <= -det;
      zero_r <= det == '0;
    end
  end

  logic [2:0] dv;
  logic [2:0] dz;
  for (genvar j = 0; j < 3; j++) begin : g_div
    logic signed [epv_pkg::OutW-1:0] q;
    epv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk(clk), .rst_n(rst_n), .en(en), .in_vld(v5_r),
      .num(top_r[j]), .den(den_r), .in_zero(zero_r),
      .out_vld(dv[j]), .quo(q), .out_zero(dz[j])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= dv[0];
    if (en) begin
      out_pos_x    <= g_div[0].q;
      out_pos_y    <= g_div[1].q;
      out_pos_z    <= g_div[2].q;
      out_singular <= dz[0];
    end
  end
  logic unused;
  assign unused = ^{dv[2:1], dz[2:1]};
endmodule
`default_nettype wire

[rtl/epv_div.sv]
// pipelined signed divider with saturation, one quotient bit per stage
// depends on epv_pkg
`timescale 1ns / 1ps
`default_nettype none
module epv_div #(
  parameter int unsigned FRAC_BITS = epv_pkg::FracBitsD
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 en,
  input  wire logic                                 in_vld,
  input  wire logic signed [epv_pkg::TopW-1:0]      num,
  input  wire logic signed [epv_pkg::DetW-1:0]      den,
  input  wire logic                                 in_zero,
  output logic                                      out_vld,
  output logic signed [epv_pkg::OutW-1:0]           quo,
  output logic                                      out_zero
);
  // 33 quotient bits suffice: anything larger saturates either way
  localparam int unsigned QB = epv_pkg::OutW + 1;
  localparam int unsigned NW = epv_pkg::TopW + FRAC_BITS;
  localparam int unsigned DW = epv_pkg::DetW;
  localparam int unsigned RW = DW + 1;
  localparam int unsigned NS = QB + 1;

  logic          v_r   [NS];
  logic          z_r   [NS];
  logic          neg_r [NS];
  logic          ovf_r [NS];
  logic [NW-1:0] n_r   [NS];
  logic [DW-1:0] d_r   [NS];
  logic [RW-1:0] rem_r [NS];
  logic [QB-1:0] q_r   [NS];

  logic [NW-1:0] un;
  logic [DW-1:0] ud;
  logic [NW-1:0] nsh;
  always_comb begin
    nsh = NW'({{FRAC_BITS{num[epv_pkg::TopW-1]}}, num} << FRAC_BITS);
    un  = num[epv_pkg::TopW-1] ? NW'(-nsh) : nsh;
    ud  = den[DW-1] ? DW'(-den) : DW'(den);
  end

  // stage 0: magnitudes and early overflow test on the high part
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
    if (en) begin
      z_r[0]   <= in_zero;
      neg_r[0] <= num[epv_pkg::TopW-1] ^ den[DW-1];
      n_r[0]   <= un;
      d_r[0]   <= ud;
      ovf_r[0] <= (RW'(un[NW-1:QB]) >= RW'(ud));
      rem_r[0] <= RW'(un[NW-1:QB]);
      q_r[0]   <= '0;
    end
  end

  // remainder stays below the divisor once no overflow, so one bit per stage
  for (genvar s = 0; s < QB; s++) begin : g_st
    logic [RW:0] sh;
    logic        ge;
    assign sh = {rem_r[s], n_r[s][QB-1-s]};
    assign ge = sh >= (RW+1)'(d_r[s]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
      if (en) begin
        z_r[s+1]   <= z_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
        n_r[s+1]   <= n_r[s];
        d_r[s+1]   <= d_r[s];
        rem_r[s+1] <= ge ? RW'(sh - (RW+1)'(d_r[s])) : RW'(sh);
        q_r[s+1]   <= {q_r[s][QB-2:0], ge};
      end
    end
  end

  function automatic logic signed [epv_pkg::OutW-1:0] OutWcast(input logic [QB-1:0] x);
    OutWcast = x[epv_pkg::OutW-1:0];
  endfunction

  logic [QB-1:0] qf;
  assign qf = q_r[NS-1];
  always_comb begin
    if (z_r[NS-1]) begin
      quo = '0;
    end else if (!neg_r[NS-1]) begin
      quo = (ovf_r[NS-1] || qf[QB-1] || qf[QB-2]) ? {1'b0, {(epv_pkg::OutW-1){1'b1}}}
                                                   : OutWcast(qf);
    end else if (ovf_r[NS-1] || (qf > {2'b01, {(QB-2){1'b0}}})) begin
      quo = {1'b1, {(epv_pkg::OutW-1){1'b0}}};
    end else begin
      quo = epv_pkg::OutW'(-qf);
    end
  end
  assign out_vld  = v_r[NS-1];
  assign out_zero = z_r[NS-1];
endmodule
`default_nettype wire

[rtl/epv_chk.sv]
// port checker for the eye position solver, bound to the top level
// depends on epv_pkg
`timescale 1ns / 1ps
`default_nettype none
module epv_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [epv_pkg::OutW-1:0] out_pos_x,
  input wire logic signed [epv_pkg::OutW-1:0] out_pos_y,
  input wire logic signed [epv_pkg::OutW-1:0] out_pos_z,
  input wire logic                          out_singular
);
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |-> out_pos_x == 0 && out_pos_y == 0 && out_pos_z == 0)
    else $error("singular word with nonzero coordinates");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_singular))
    else $error("stalled output changed");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule
bind eye_position_from_view_matrix epv_chk u_epv_chk (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_pos_x(out_pos_x),
  .out_pos_y(out_pos_y), .out_pos_z(out_pos_z), .out_singular(out_singular)
);
`default_nettype wire

[tb/tb_top.sv]
// self-checking bench for the eye position solver (cramer 3x3 solve, no state)
// depends on epv_pkg and the rtl top eye_position_from_view_matrix
// directed matrix table, then random matrices under several idle and stall mixes
`timescale 1ns / 1ps
module tb_top;
  localparam int InW       = epv_pkg::InW;
  localparam int OutW      = epv_pkg::OutW;
  localparam int FRAC      = 16;
  localparam int LATENCY   = 39;
  localparam int LIMIT     = 400000;
  localparam int PHASE_LEN = 460;
  localparam int HOLD_LEN  = 300;

  // one matrix word: element k is row k/4, column k%4 (column 3 is the offset)
  typedef logic [11:0][InW-1:0] mat_t;
  typedef struct packed {
    logic [OutW-1:0] x;
    logic [OutW-1:0] y;
    logic [OutW-1:0] z;
    logic            sing;
  } eye_t;
  typedef struct packed {
    mat_t m;
    bit   known;
    eye_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [InW-1:0] in_f [12];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OutW-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic out_singular;

  eye_t      pending_eyes[$];
  plan_row_t plan[$];
  int        errors = 0;
  int        words_in = 0;
  int        words_out = 0;
  int        singular_seen = 0;
  int        saturated_seen = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_req = 1'b0;
  bit        running = 1'b0;

  initial begin
    for (int k = 0; k < 12; k++) in_f[k] = '0;
  end

  eye_position_from_view_matrix dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_row0_col0(in_f[0]), .in_row0_col1(in_f[1]),
    .in_row0_col2(in_f[2]), .in_row0_offset(in_f[3]),
    .in_row1_col0(in_f[4]), .in_row1_col1(in_f[5]),
    .in_row1_col2(in_f[6]), .in_row1_offset(in_f[7]),
    .in_row2_col0(in_f[8]), .in_row2_col1(in_f[9]),
    .in_row2_col2(in_f[10]), .in_row2_offset(in_f[11]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_singular(out_singular)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // eye point from the matrix: cofactors, determinant, weighted sums, divide
  function automatic eye_t solve_eye(mat_t m);
    logic signed [127:0] n [3][3];
    logic signed [127:0] t [3];
    logic signed [127:0] c [3][3];
    logic signed [127:0] det, num, q;
    logic [OutW-1:0] co [3];
    eye_t r;
    int a, b;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) n[i][j] = $signed(m[i*4+j]);
      t[i] = $signed(m[i*4+3]);
    end
    // c0 = n1 x n2, c1 = n2 x n0, c2 = n0 x n1
    for (int k = 0; k < 3; k++) begin
      a = (k + 1) % 3;
      b = (k + 2) % 3;
      for (int x = 0; x < 3; x++)
        c[k][x] = n[a][(x+1)%3] * n[b][(x+2)%3] - n[a][(x+2)%3] * n[b][(x+1)%3];
    end
    det = n[0][0] * c[0][0] + n[0][1] * c[0][1] + n[0][2] * c[0][2];
    if (det == 0) begin
      r = '{x: '0, y: '0, z: '0, sing: 1'b1};
      return r;
    end
    for (int j = 0; j < 3; j++) begin
      num = (c[0][j] * t[0] + c[1][j] * t[1] + c[2][j] * t[2]) <<< FRAC;
      q = num / (-det);  // truncates toward zero
      if (q > 128'sd2147483647) co[j] = 32'h7fffffff;
      else if (q < -128'sd2147483648) co[j] = 32'h80000000;
      else co[j] = q[OutW-1:0];
    end
    r = '{x: co[0], y: co[1], z: co[2], sing: 1'b0};
    return r;
  endfunction

  function automatic mat_t mk(int a0, int a1, int a2, int a3, int b0, int b1, int b2,
                              int b3, int c0, int c1, int c2, int c3);
    mat_t m;
    int v [12];
    v = '{a0, a1, a2, a3, b0, b1, b2, b3, c0, c1, c2, c3};
    for (int k = 0; k < 12; k++) m[k] = v[k][InW-1:0];
    return m;
  endfunction

  function automatic int rnd_full();
    return int'($signed(24'($urandom)));
  endfunction

  function automatic int rnd_near(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // random matrix: well-conditioned near-diagonal ones with random offsets,
  // plus full-range noise, singular ones and tiny determinants
  function automatic mat_t rand_matrix();
    mat_t m;
    int kind, one;
    one = 1 << FRAC;
    kind = $urandom_range(99);
    for (int k = 0; k < 12; k++) m[k] = 24'(rnd_full());
    if (kind < 40) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i*4+j] = 24'(rnd_near(one / 4) + ((i == j) ? ((kind & 1) ? one : -one) : 0));
    end else if (kind < 55) begin
      // repeated or zero row gives a zero determinant
      for (int j = 0; j < 4; j++) m[8+j] = (kind & 1) ? m[4+j] : ((j == 3) ? m[11] : '0);
    end else if (kind < 65) begin
      // tiny rotation terms push the quotient into saturation
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i*4+j] = 24'(rnd_near(3));
    end
    return m;
  endfunction

  // drive one word and hold it until taken; acceptance is sampled at the
  // falling edge so the decision is race-free against the rising edge
  task automatic send_word(mat_t m);
    bit taken;
    for (int k = 0; k < 12; k++) in_f[k] <= m[k];
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      if (taken) begin
        pending_eyes.push_back(solve_eye(m));
        words_in++;
      end
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_gap();
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    @(posedge clk);
    while (!running) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < HOLD_LEN) begin
          @(posedge clk);
          held++;
        end
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(negedge clk) begin
    eye_t want;
    if (rst_n && out_valid && out_ready) begin
      words_out++;
      if (pending_eyes.size() == 0) begin
        $display("%0t: result word with nothing pending: x=%h y=%h z=%h s=%b", $time,
                 out_pos_x, out_pos_y, out_pos_z, out_singular);
        errors++;
      end else begin
        want = pending_eyes.pop_front();
        if (want.sing) singular_seen++;
        if (want.x == 32'h7fffffff || want.x == 32'h80000000) saturated_seen++;
        if (out_pos_x !== want.x) begin
          $display("%0t: pos_x expected %h actual %h", $time, want.x, out_pos_x);
          errors++;
        end
        if (out_pos_y !== want.y) begin
          $display("%0t: pos_y expected %h actual %h", $time, want.y, out_pos_y);
          errors++;
        end
        if (out_pos_z !== want.z) begin
          $display("%0t: pos_z expected %h actual %h", $time, want.z, out_pos_z);
          errors++;
        end
        if (out_singular !== want.sing) begin
          $display("%0t: singular expected %b actual %b", $time, want.sing, out_singular);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycles,
               pending_eyes.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int one, mx, mn, tail;
    eye_t model_eye;
    one = 1 << FRAC;
    mx  = 8388607;
    mn  = -8388608;

    // directed table: expected typed in only where obvious
    plan.push_back('{mk(one,0,0,0, 0,one,0,0, 0,0,one,0), 1'b1, '{0, 0, 0, 1'b0}});
    plan.push_back('{mk(0,0,0,0, 0,0,0,0, 0,0,0,0), 1'b1, '{0, 0, 0, 1'b1}});
    // identity: eye sits at minus the offsets
    plan.push_back('{mk(one,0,0,one, 0,one,0,2*one, 0,0,one,3*one), 1'b1,
                     '{-32'sd65536, -32'sd131072, -32'sd196608, 1'b0}});
    // every term at an extreme: rows equal, so singular
    plan.push_back('{mk(mx,mx,mx,mx, mx,mx,mx,mx, mx,mx,mx,mx), 1'b1, '{0, 0, 0, 1'b1}});
    plan.push_back('{mk(mn,mn,mn,mn, mn,mn,mn,mn, mn,mn,mn,mn), 1'b1, '{0, 0, 0, 1'b1}});
    // unit lsb diagonal with extreme offsets saturates both ways
    plan.push_back('{mk(1,0,0,mx, 0,1,0,mn, 0,0,1,mx), 1'b1,
                     '{32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0}});
    plan.push_back('{mk(1,0,0,mn, 0,1,0,mx, 0,0,1,0), 1'b1,
                     '{32'h7fffffff, 32'h80000000, 0, 1'b0}});
    // extreme diagonals, then extreme terms in mixed signs
    plan.push_back('{mk(mx,0,0,mn, 0,mn,0,mx, 0,0,mx,mn), 1'b0, '0});
    plan.push_back('{mk(mn,0,0,mx, 0,mn,0,mn, 0,0,mn,mx), 1'b0, '0});
    plan.push_back('{mk(mn,mx,mn,mx, mx,mn,mx,mn, mn,mn,mx,mx), 1'b0, '0});
    plan.push_back('{mk(-1,-1,-1,-1, -1,mx,0,mx, 0,-1,mn,mn), 1'b0, '0});
    // rotation about z by 90 degrees, with offsets
    plan.push_back('{mk(0,-one,0,one, one,0,0,-one, 0,0,one,one/2), 1'b0, '0});
    // zero column makes the determinant vanish despite nonzero rows
    plan.push_back('{mk(one,0,0,5, 2*one,0,3,7, -one,0,9,mx), 1'b1, '{0, 0, 0, 1'b1}});
    // tiny determinant, result truncated toward zero
    plan.push_back('{mk(3,0,0,1, 0,7,0,-1, 0,0,-5,2), 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    running = 1'b1;

    // directed words, no idling
    foreach (plan[r]) begin
      model_eye = solve_eye(plan[r].m);
      send_word(plan[r].m);
      if (plan[r].known) begin
        if (model_eye !== plan[r].want)
          $display("%0t: table row %0d disagrees with prediction: expected %h got %h",
                   $time, r, plan[r].want, model_eye);
        pending_eyes[pending_eyes.size()-1] = plan[r].want;
      end
    end

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int i = 0; i < PHASE_LEN; i++) begin
        send_word(rand_matrix());
        // stretches without any idling inside each phase
        if ((i / 50) % 3 != 0) send_gap();
      end
    end
    in_valid <= 1'b0;

    recv_stall_pct = 0;
    while (pending_eyes.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < LATENCY + 20) begin
      @(posedge clk);
      tail++;
    end

    $display("%0d matrix words sent, %0d results checked", words_in, words_out);
    $display("%0d singular, %0d saturated x, with idle and stall mixes and one long hold",
             singular_seen, saturated_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/epv_pkg.sv
rtl/epv_div.sv
rtl/eye_position_from_view_matrix.sv
rtl/epv_chk.sv
tb/tb_top.sv
